### hdl/vlw3d_pkg.sv
// Shared types and constants for the 3D voxel line walker.
// No dependencies; imported by the top level.
package vlw3d_pkg;

  localparam int AXES = 3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_WALK
  } walk_state_t;

endpackage

### hdl/vlw3d_axis_step.sv
// One axis of the line walk: error update and unit move for a single step.
// Standalone; instantiated once per axis by voxel_line_walker_3d_core.
module vlw3d_axis_step #(
  parameter int COORD_BITS = 5
) (
  input  logic [COORD_BITS-1:0] pos,
  input  logic [COORD_BITS:0]   err,
  input  logic [COORD_BITS-1:0] delta,
  input  logic                  dir_neg,
  input  logic [COORD_BITS-1:0] total,
  output logic [COORD_BITS-1:0] pos_next,
  output logic [COORD_BITS:0]   err_next
);

  logic [COORD_BITS:0] err_sum;
  logic [COORD_BITS:0] total_ext;
  logic                move;

  always_comb begin
    total_ext = {1'b0, total};
    err_sum   = err + {1'b0, delta};
    move      = (err_sum > total_ext);
    err_next  = move ? (err_sum - total_ext) : err_sum;
    if (!move) begin
      pos_next = pos;
    end else if (dir_neg) begin
      pos_next = pos - {{(COORD_BITS-1){1'b0}}, 1'b1};
    end else begin
      pos_next = pos + {{(COORD_BITS-1){1'b0}}, 1'b1};
    end
  end

endmodule

### hdl/voxel_line_walker_3d_core.sv
// Integer 3D line walk between a start and an end voxel. An item is taken
// when in_ready is high; the block then emits max(|dx|,|dy|,|dz|)+1 points,
// one per cycle while out_ready stays high, the last one flagged and equal to
// the end voxel. The single step loop advances all three axes once per emitted
// point into the output register. in_ready is low while a line is being
// walked.
// Depends on vlw3d_pkg and vlw3d_axis_step.
module voxel_line_walker_3d_core #(
  parameter int COORD_BITS = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] start_z,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [COORD_BITS-1:0] end_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] point_x,
  output logic [COORD_BITS-1:0] point_y,
  output logic [COORD_BITS-1:0] point_z,
  output logic [COORD_BITS-1:0] point_index,
  output logic                  last_point
);

  import vlw3d_pkg::*;

  walk_state_t state, state_next;

  logic [COORD_BITS-1:0] cur_pos      [AXES];
  logic [COORD_BITS:0]   axis_error   [AXES];
  logic [COORD_BITS-1:0] axis_delta   [AXES];
  logic                  axis_dir_neg [AXES];
  logic [COORD_BITS-1:0] step_total;
  logic [COORD_BITS-1:0] step_count;

  logic [COORD_BITS-1:0] in_start [AXES];
  logic [COORD_BITS-1:0] in_end   [AXES];
  logic [COORD_BITS-1:0] init_delta [AXES];
  logic                  init_neg   [AXES];
  logic [COORD_BITS-1:0] init_total;
  logic [COORD_BITS-1:0] pos_step [AXES];
  logic [COORD_BITS:0]   err_step [AXES];

  logic accept;
  logic load;
  logic at_last;

  assign in_start[0] = start_x;
  assign in_start[1] = start_y;
  assign in_start[2] = start_z;
  assign in_end[0]   = end_x;
  assign in_end[1]   = end_y;
  assign in_end[2]   = end_z;

  // Line setup straight from the input item
  for (genvar a = 0; a < AXES; a++) begin : g_axis
    assign init_neg[a]   = (in_end[a] < in_start[a]);
    assign init_delta[a] = init_neg[a] ? (in_start[a] - in_end[a])
                                       : (in_end[a] - in_start[a]);

    vlw3d_axis_step #(
      .COORD_BITS(COORD_BITS)
    ) u_step (
      .pos      (cur_pos[a]),
      .err      (axis_error[a]),
      .delta    (axis_delta[a]),
      .dir_neg  (axis_dir_neg[a]),
      .total    (step_total),
      .pos_next (pos_step[a]),
      .err_next (err_step[a])
    );
  end

  always_comb begin
    init_total = init_delta[0];
    if (init_delta[1] > init_total) begin
      init_total = init_delta[1];
    end
    if (init_delta[2] > init_total) begin
      init_total = init_delta[2];
    end
  end

  assign at_last = (step_count == step_total);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (load && at_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready = 1'b0;
    load     = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_WALK: load = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
        load     = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk datapath and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int a = 0; a < AXES; a++) begin
        cur_pos[a]      <= in_start[a];
        axis_delta[a]   <= init_delta[a];
        axis_dir_neg[a] <= init_neg[a];
        axis_error[a]   <= {1'b0, init_delta[a]};
      end
      step_total <= init_total;
      step_count <= '0;
    end else if (load) begin
      point_x     <= cur_pos[0];
      point_y     <= cur_pos[1];
      point_z     <= cur_pos[2];
      point_index <= step_count;
      last_point  <= at_last;
      if (!at_last) begin
        for (int a = 0; a < AXES; a++) begin
          cur_pos[a]    <= pos_step[a];
          axis_error[a] <= err_step[a];
        end
        step_count <= step_count + {{(COORD_BITS-1){1'b0}}, 1'b1};
      end
    end
  end

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_WALK) && (step_count == '0))
    else $error("walk did not start after item accept");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (step_count <= step_total))
    else $error("step count ran past step total");

  a_error_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> ((axis_error[0] <= {1'b0, step_total}) &&
                            (axis_error[1] <= {1'b0, step_total}) &&
                            (axis_error[2] <= {1'b0, step_total})))
    else $error("axis error above step total");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (load && at_last) |=> (state == ST_IDLE) && out_valid && last_point &&
                          (point_index == step_total))
    else $error("last point did not close the line");

endmodule
